/* design/tln_pkg.sv */
// Shared types, codes and the name key normalization for the two-level name table.
package tln_pkg;

    // Characters of a name key that take part in a compare.
    localparam int NAME_CHARS = 8;

    typedef enum logic [1:0] {
        OP_MKDIR  = 2'd0,
        OP_MKFILE = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TABLE_FULL   = 3'd1,
        ST_DIR_MISSING  = 3'd2,
        ST_DIR_FULL     = 3'd3,
        ST_FILE_MISSING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MKDIR,
        S_DSCAN,
        S_DTOT,
        S_FSCAN,
        S_MVRD,
        S_MVWR,
        S_RES
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan_dir;
        logic    scan_file;
        logic    dir_take;
        logic    file_take;
        logic    mkdir;
        logic    mkfile;
        logic    mv_rd;
        logic    mv_wr;
        logic    set_status;
        t_status status;
        logic    push;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic dir_room;
        logic file_room;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_st;

    // Keeps the bytes up to the first zero byte, within NAME_CHARS characters.
    function automatic logic [63:0] norm_key(input logic [63:0] key);
        logic [63:0] res;
        logic        alive;
        res   = '0;
        alive = 1'b1;
        for (int c = 0; c < 8; c++) begin
            if (c >= NAME_CHARS || key[8*c +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[8*c +: 8] = key[8*c +: 8];
            end
        end
        return res;
    endfunction

endpackage

/* design/tln_ctrl.sv */
// Request sequencer of the two-level name table.
module tln_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  tln_pkg::t_dp_st i_st,
    output tln_pkg::t_dp_cmd o_cmd
);
    import tln_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DSCAN;
                end
            end
            S_MKDIR: begin
                if (i_st.dir_room) begin
                    o_cmd.mkdir = 1'b1;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_TABLE_FULL;
                end
                n_state = S_RES;
            end
            S_DSCAN: begin
                // A new directory needs no lookup.
                if (i_st.op == OP_MKDIR) begin
                    n_state = S_MKDIR;
                end else begin
                    o_cmd.scan_dir = 1'b1;
                    if (i_st.hit) begin
                        o_cmd.dir_take = 1'b1;
                        n_state        = S_DTOT;
                    end else if (i_st.miss) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DIR_MISSING;
                        n_state          = S_RES;
                    end
                end
            end
            S_DTOT: begin
                if (i_st.op == OP_MKFILE) begin
                    if (i_st.file_room) begin
                        o_cmd.mkfile = 1'b1;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DIR_FULL;
                    end
                    n_state = S_RES;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_FSCAN;
                end
            end
            S_FSCAN: begin
                o_cmd.scan_file = 1'b1;
                if (i_st.hit) begin
                    o_cmd.file_take = 1'b1;
                    n_state = (i_st.op == OP_DELETE) ? S_MVRD : S_RES;
                end else if (i_st.miss) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FILE_MISSING;
                    n_state          = S_RES;
                end
            end
            S_MVRD: begin
                o_cmd.mv_rd = 1'b1;
                n_state     = S_MVWR;
            end
            S_MVWR: begin
                o_cmd.mv_wr = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/tln_dp.sv */
// Key stores, scan counters and result register of the two-level name table.
module tln_dp #(
    parameter int MAX_DIRS  = 16,
    parameter int MAX_FILES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tln_pkg::t_dp_cmd i_cmd,
    output tln_pkg::t_dp_st  o_st,
    input  tln_pkg::t_op     i_op,
    input  logic [63:0]      i_dir_name,
    input  logic [63:0]      i_file_name,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output tln_pkg::t_status o_status,
    output logic [3:0]       o_dir_slot,
    output logic [3:0]       o_file_slot
);
    import tln_pkg::*;

    localparam int DW     = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int FW     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int DCW    = $clog2(MAX_DIRS + 1);
    localparam int FCW    = $clog2(MAX_FILES + 1);
    localparam int SIW    = (DCW > FCW) ? DCW : FCW;
    localparam int FDEPTH = MAX_DIRS * MAX_FILES;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

    logic [63:0]    dir_keys  [MAX_DIRS];
    logic [FCW-1:0] file_tots [MAX_DIRS];
    logic [63:0]    file_keys [FDEPTH];

    t_op            r_op;
    logic [63:0]    r_dkey, r_fkey;
    logic [DCW-1:0] r_dir_total;
    logic [SIW-1:0] r_iss, r_cmp_idx;
    logic           r_cmp_vld, r_cmp_file;
    logic [63:0]    r_dq, r_fq;
    logic [FCW-1:0] r_ftot_q;
    logic [DW-1:0]  r_didx;
    logic [FW-1:0]  r_fidx;
    logic [FAW-1:0] r_base;
    t_status        r_status;
    logic           r_o_vld;
    t_status        r_o_status;
    logic [3:0]     r_o_dslot, r_o_fslot;

    logic           scan, issue, f_rd, f_we;
    logic [SIW-1:0] limit;
    logic [FCW-1:0] n_last;
    logic [FAW-1:0] f_rd_addr, f_wr_addr;
    logic [63:0]    f_wd;
    logic [DW+3:0]  dslot_ext;
    logic [FW+3:0]  fslot_ext;

    always_comb begin
        scan      = i_cmd.scan_dir | i_cmd.scan_file;
        limit     = i_cmd.scan_file ? SIW'(r_ftot_q) : SIW'(r_dir_total);
        issue     = scan && (r_iss < limit);
        n_last    = r_ftot_q - FCW'(1);
        f_rd      = (issue && i_cmd.scan_file) || i_cmd.mv_rd;
        f_rd_addr = i_cmd.mv_rd ? r_base + FAW'(n_last) : r_base + FAW'(r_iss);
        f_we      = i_cmd.mkfile | i_cmd.mv_wr;
        // A delete refills the freed slot with the directory's last file.
        f_wr_addr = i_cmd.mv_wr ? r_base + FAW'(r_fidx) : r_base + FAW'(r_ftot_q);
        f_wd      = i_cmd.mv_wr ? r_fq : r_fkey;
        dslot_ext = {4'd0, r_didx};
        fslot_ext = {4'd0, r_fidx};

        o_st.op        = r_op;
        o_st.dir_room  = r_dir_total < DCW'(MAX_DIRS);
        o_st.file_room = r_ftot_q < FCW'(MAX_FILES);
        o_st.hit       = r_cmp_vld && (r_cmp_file ? (r_fq == r_fkey) : (r_dq == r_dkey));
        o_st.miss      = scan && !r_cmp_vld && !(r_iss < limit);
        o_st.out_free  = !r_o_vld || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_total <= '0;
            r_cmp_vld   <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cmd.mkdir) begin
                r_dir_total <= r_dir_total + DCW'(1);
            end
            if (i_cmd.load || i_cmd.scan_start) begin
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= issue;
            end
            if (i_cmd.push) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_dkey   <= norm_key(i_dir_name);
            r_fkey   <= norm_key(i_file_name);
            r_status <= ST_OK;
            r_didx   <= '0;
            r_fidx   <= '0;
            r_iss    <= '0;
        end else if (i_cmd.scan_start) begin
            r_iss <= '0;
        end else if (issue) begin
            r_iss <= r_iss + SIW'(1);
        end
        if (issue) begin
            r_cmp_idx  <= r_iss;
            r_cmp_file <= i_cmd.scan_file;
        end
        if (i_cmd.dir_take) begin
            r_didx <= r_cmp_idx[DW-1:0];
            r_base <= FAW'(r_cmp_idx[DW-1:0]) * FAW'(MAX_FILES);
        end
        if (i_cmd.file_take) begin
            r_fidx <= r_cmp_idx[FW-1:0];
        end
        if (i_cmd.mkdir) begin
            r_didx <= r_dir_total[DW-1:0];
        end
        if (i_cmd.mkfile) begin
            r_fidx <= r_ftot_q[FW-1:0];
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.push) begin
            r_o_status <= r_status;
            r_o_dslot  <= dslot_ext[3:0];
            r_o_fslot  <= fslot_ext[3:0];
        end
    end

    // Directory key store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mkdir) begin
            dir_keys[r_dir_total[DW-1:0]] <= r_dkey;
        end
        if (issue && i_cmd.scan_dir) begin
            r_dq <= dir_keys[r_iss[DW-1:0]];
        end
    end

    // File count per directory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mkdir) begin
            file_tots[r_dir_total[DW-1:0]] <= '0;
        end else if (i_cmd.mkfile) begin
            file_tots[r_didx] <= r_ftot_q + FCW'(1);
        end else if (i_cmd.mv_wr) begin
            file_tots[r_didx] <= n_last;
        end
        if (i_cmd.dir_take) begin
            r_ftot_q <= file_tots[r_cmp_idx[DW-1:0]];
        end
    end

    // File key store, one row of MAX_FILES entries per directory.
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            file_keys[f_wr_addr] <= f_wd;
        end
        if (f_rd) begin
            r_fq <= file_keys[f_rd_addr];
        end
    end

    assign o_m_tvalid  = r_o_vld;
    assign o_status    = r_o_status;
    assign o_dir_slot  = r_o_dslot;
    assign o_file_slot = r_o_fslot;

endmodule

/* design/two_level_name_table.sv */
// Two-level name table: directory keys, each with a list of file keys.
// One request is handled at a time. Requests other than create-directory scan
// the directory keys one per cycle from slot 0 up to the first match, then a
// delete or search scans the matched directory's file keys the same way,
// through the single read port of each key store. A result waits in an output
// register and the next request is taken while it waits. Slots in the result
// are the low 4 bits of the slot index. Keys are cut at the first zero byte
// before they are stored or compared; duplicate names are kept and the first
// match wins.
module two_level_name_table #(
    parameter int MAX_DIRS  = 16,
    parameter int MAX_FILES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // op[1:0], dir_name[65:2], file_name[129:66], zeros
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // status[2:0], dir_slot[6:3], file_slot[10:7], zeros
);
    import tln_pkg::*;

    t_dp_cmd    cmd;
    t_dp_st     st;
    t_status    status;
    logic [3:0] dir_slot, file_slot;

    tln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tln_dp #(
        .MAX_DIRS  (MAX_DIRS),
        .MAX_FILES (MAX_FILES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_op        (t_op'(s_tdata[1:0])),
        .i_dir_name  (s_tdata[65:2]),
        .i_file_name (s_tdata[129:66]),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_status    (status),
        .o_dir_slot  (dir_slot),
        .o_file_slot (file_slot)
    );

    assign m_tdata = {5'd0, file_slot, dir_slot, status};

`ifndef ASSERT_OFF
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> st.out_free)
        else $error("result pushed into an occupied output register");

    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st.hit && st.miss))
        else $error("scan reports a match and a miss together");

    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mv_wr |-> $past(cmd.mv_rd))
        else $error("delete refill written without reading the last file");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |-> !cmd.push)
        else $error("request taken while a result is being pushed");
`endif

endmodule

/* bench/tb_two_level_name_table.sv */
// Self-checking testbench for the two-level name table: directed and random requests.
module tb_two_level_name_table;
    timeunit 1ns;
    timeprecision 1ps;

    import tln_pkg::*;

    localparam int MAX_DIRS    = 16;
    localparam int MAX_FILES   = 16;
    localparam int PHASE_ITEMS = 425;
    localparam int DIR_POOL    = 10;
    localparam int FILE_POOL   = 12;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        t_status    status;
        logic [3:0] dir_slot;
        logic [3:0] file_slot;
    } t_reply;

    // Mirror of the table contents plus the queue of replies still owed by the block.
    class name_table_scoreboard;
        logic [63:0] dir_keys [MAX_DIRS];
        int          dir_count;
        int          file_counts [MAX_DIRS];
        logic [63:0] file_keys [MAX_DIRS][MAX_FILES];
        t_reply      pending_replies [$];
        int          errors;
        int          checked;
        int          status_seen [5];

        function new();
            dir_count = 0;
            errors    = 0;
            checked   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Keeps the bytes below the first zero byte.
        function logic [63:0] trim_key(logic [63:0] k);
            logic [63:0] r;
            r = '0;
            for (int c = 0; c < NAME_CHARS; c++) begin
                if (k[8*c +: 8] == 8'd0) break;
                r[8*c +: 8] = k[8*c +: 8];
            end
            return r;
        endfunction

        function t_reply predict_reply(t_op op, logic [63:0] dname, logic [63:0] fname);
            t_reply      r;
            int          d;
            int          k;
            int          n;
            logic [63:0] dk;
            logic [63:0] fk;
            r.status    = ST_OK;
            r.dir_slot  = '0;
            r.file_slot = '0;
            dk = trim_key(dname);
            fk = trim_key(fname);
            if (op == OP_MKDIR) begin
                if (dir_count < MAX_DIRS) begin
                    dir_keys[dir_count]    = dk;
                    file_counts[dir_count] = 0;
                    r.dir_slot             = dir_count[3:0];
                    dir_count++;
                end else begin
                    r.status = ST_TABLE_FULL;
                end
                return r;
            end
            d = -1;
            for (int i = 0; i < dir_count; i++) begin
                if (dir_keys[i] == dk) begin
                    d = i;
                    break;
                end
            end
            if (d < 0) begin
                r.status = ST_DIR_MISSING;
                return r;
            end
            r.dir_slot = d[3:0];
            n = file_counts[d];
            if (op == OP_MKFILE) begin
                if (n < MAX_FILES) begin
                    file_keys[d][n] = fk;
                    file_counts[d]  = n + 1;
                    r.file_slot     = n[3:0];
                end else begin
                    r.status = ST_DIR_FULL;
                end
                return r;
            end
            k = -1;
            for (int i = 0; i < n; i++) begin
                if (file_keys[d][i] == fk) begin
                    k = i;
                    break;
                end
            end
            if (k < 0) begin
                r.status = ST_FILE_MISSING;
                return r;
            end
            r.file_slot = k[3:0];
            // A delete fills the hole with the directory's last file.
            if (op == OP_DELETE) begin
                file_keys[d][k] = file_keys[d][n-1];
                file_counts[d]  = n - 1;
            end
            return r;
        endfunction

        function void note_request(logic [135:0] data);
            pending_replies.push_back(predict_reply(t_op'(data[1:0]), data[65:2], data[129:66]));
        endfunction

        function void check_reply(logic [15:0] data);
            t_reply want;
            t_reply got;
            got.status    = t_status'(data[2:0]);
            got.dir_slot  = data[6:3];
            got.file_slot = data[10:7];
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with none expected: status %0d dir_slot %0d file_slot %0d",
                         $time, got.status, got.dir_slot, got.file_slot);
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            if (int'(want.status) < 5) status_seen[int'(want.status)]++;
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.dir_slot !== want.dir_slot) begin
                errors++;
                $display("%0t: dir_slot expected %0d actual %0d",
                         $time, want.dir_slot, got.dir_slot);
            end
            if (got.file_slot !== want.file_slot) begin
                errors++;
                $display("%0t: file_slot expected %0d actual %0d",
                         $time, want.file_slot, got.file_slot);
            end
        endfunction
    endclass

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;   // op[1:0], dir_name[65:2], file_name[129:66], zeros
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;         // status[2:0], dir_slot[6:3], file_slot[10:7], zeros

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;

    logic [63:0] dir_pool [DIR_POOL];
    int          dir_pool_len [DIR_POOL];
    logic [63:0] file_pool [FILE_POOL];
    int          file_pool_len [FILE_POOL];

    name_table_scoreboard sb = new();

    two_level_name_table #(
        .MAX_DIRS  (MAX_DIRS),
        .MAX_FILES (MAX_FILES)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_reply(m_tdata);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycles, sb.pending_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] make_name(int len);
        logic [63:0] k;
        k = '0;
        for (int c = 0; c < len; c++) k[8*c +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Sometimes puts random bytes above the terminating zero of a name of at most six bytes; the name must still match.
    function automatic logic [63:0] add_tail(logic [63:0] k, int len);
        logic [63:0] r;
        r = k;
        if (len <= 6 && $urandom_range(0, 99) < 30) begin
            for (int c = len + 1; c < 8; c++) r[8*c +: 8] = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    function automatic logic [63:0] pick_dir_name();
        int sel;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return {$urandom, $urandom};
        if (r < 10) return (r == 8) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
        sel = $urandom_range(0, DIR_POOL - 1);
        return add_tail(dir_pool[sel], dir_pool_len[sel]);
    endfunction

    function automatic logic [63:0] pick_file_name();
        int sel;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return {$urandom, $urandom};
        if (r < 10) return (r == 8) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
        sel = $urandom_range(0, FILE_POOL - 1);
        return add_tail(file_pool[sel], file_pool_len[sel]);
    endfunction

    task automatic send_request(input t_op op, input logic [63:0] dname,
                                input logic [63:0] fname);
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, fname, dname, op};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_random_request();
        int  r;
        t_op op;
        r = $urandom_range(0, 99);
        if (r < 8) op = OP_MKDIR;
        else if (r < 50) op = OP_MKFILE;
        else if (r < 70) op = OP_DELETE;
        else op = OP_SEARCH;
        send_request(op, pick_dir_name(), pick_file_name());
    endtask

    initial begin
        for (int i = 0; i < DIR_POOL; i++) begin
            dir_pool_len[i] = $urandom_range(1, 8);
            dir_pool[i]     = make_name(dir_pool_len[i]);
        end
        for (int i = 0; i < FILE_POOL; i++) begin
            file_pool_len[i] = $urandom_range(1, 8);
            file_pool[i]     = make_name(file_pool_len[i]);
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: every lookup misses.
        send_request(OP_SEARCH, 64'd0, 64'd0);
        send_request(OP_MKFILE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
        send_request(OP_DELETE, 64'h41, 64'h42);
        // Extreme names, and a name whose tail beyond the first zero byte is junk.
        send_request(OP_MKDIR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_MKDIR, 64'd0, 64'h0123_4567_89AB_CDEF);
        send_request(OP_MKDIR, 64'h0000_5A00_7700_0041, 64'd0);
        send_request(OP_MKFILE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_MKFILE, 64'h1234_5678_9ABC_DE00, 64'd0);
        send_request(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 64'h12);
        send_request(OP_SEARCH, 64'd0, 64'hFF00_0000_0000_0000);
        send_request(OP_MKFILE, 64'h41, 64'h58);
        send_request(OP_MKFILE, 64'hEE00_0041, 64'h59);
        send_request(OP_MKFILE, 64'h41, 64'h5A);
        // Deleting the first file moves the last one into slot 0.
        send_request(OP_DELETE, 64'h41, 64'h58);
        send_request(OP_SEARCH, 64'h41, 64'h5A);
        send_request(OP_DELETE, 64'h41, 64'h33_0000_0058);
        send_request(OP_SEARCH, 64'h41, 64'h59);
        // A duplicate directory never wins a lookup over the first one.
        send_request(OP_MKDIR, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7);
        send_request(OP_MKFILE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
        send_request(OP_DELETE, 64'd0, 64'd0);
        send_request(OP_SEARCH, 64'd0, 64'd0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 66;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 66;
                end
                default: begin
                    src_idle_pct   = 9;
                    sink_stall_pct = 9;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d replies over four handshake pacing phases.", sb.checked);
        $display("Outcomes: ok %0d, table full %0d, dir missing %0d,",
                 sb.status_seen[ST_OK], sb.status_seen[ST_TABLE_FULL],
                 sb.status_seen[ST_DIR_MISSING]);
        $display("          dir full %0d, file missing %0d",
                 sb.status_seen[ST_DIR_FULL], sb.status_seen[ST_FILE_MISSING]);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
